### design/ubxtmc_pkg.sv
// Shared types and constants for the UBX time message checker.
// No dependencies; every module of the checker imports this package.
`timescale 1ns / 1ps

package ubxtmc_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_CLASS  = 2'd0;
    localparam logic [1:0] REG_ID     = 2'd1;
    localparam logic [1:0] REG_LENGTH = 2'd2;

    localparam logic [7:0]  CLASS_RESET  = 8'd13;
    localparam logic [7:0]  ID_RESET     = 8'd18;
    localparam logic [15:0] LENGTH_RESET = 16'd56;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LENGTH   = 3'd1;
    localparam logic [2:0] ST_MONTH    = 3'd2;
    localparam logic [2:0] ST_DAY      = 3'd3;
    localparam logic [2:0] ST_HOUR     = 3'd4;
    localparam logic [2:0] ST_MINUTE   = 3'd5;
    localparam logic [2:0] ST_SECOND   = 3'd6;
    localparam logic [2:0] ST_CHECKSUM = 3'd7;

    // Payload byte positions of the captured fields.
    localparam logic [15:0] POS_YEAR_LO = 16'd8;
    localparam logic [15:0] POS_YEAR_HI = 16'd9;
    localparam logic [15:0] POS_MONTH   = 16'd10;
    localparam logic [15:0] POS_DAY     = 16'd11;
    localparam logic [15:0] POS_HOUR    = 16'd12;
    localparam logic [15:0] POS_MINUTE  = 16'd13;
    localparam logic [15:0] POS_SECOND  = 16'd14;

    typedef struct packed {
        logic [7:0]  message_class;
        logic [7:0]  message_id;
        logic [15:0] expected_length;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
    } result_t;

endpackage

### design/ubxtmc_regs.sv
// APB configuration registers of the UBX time message checker.
// Depends on ubxtmc_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module ubxtmc_regs import ubxtmc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [7:0]  class_reg;
    logic [7:0]  id_reg;
    logic [15:0] length_reg;
    logic        wr_en;
    logic [1:0]  reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite & pready;
    assign reg_index = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            class_reg  <= CLASS_RESET;
            id_reg     <= ID_RESET;
            length_reg <= LENGTH_RESET;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_CLASS:  class_reg  <= pwdata[7:0];
                REG_ID:     id_reg     <= pwdata[7:0];
                REG_LENGTH: length_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_CLASS:  prdata = {24'd0, class_reg};
            REG_ID:     prdata = {24'd0, id_reg};
            REG_LENGTH: prdata = {16'd0, length_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.message_class   = class_reg;
    assign cfg.message_id      = id_reg;
    assign cfg.expected_length = length_reg;

endmodule

### design/ubxtmc_frame.sv
// Frame tracker: phase, byte counter, Fletcher sums, field captures and result decision.
// Depends on ubxtmc_pkg for cfg_t, result_t, status codes and field positions.
`timescale 1ns / 1ps

module ubxtmc_frame import ubxtmc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] data_byte,
    input  logic       frame_start,
    input  cfg_t       cfg,
    output logic       emit,
    output result_t    emit_data
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_CK_A    = 3'd3;
    localparam logic [2:0] PH_CK_B    = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] dlen_reg, dlen_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [15:0] year_reg, year_next;
    logic [7:0]  month_reg, month_next;
    logic [7:0]  day_reg, day_next;
    logic [7:0]  hour_reg, hour_next;
    logic [7:0]  minute_reg, minute_next;
    logic [7:0]  second_reg, second_next;
    logic [7:0]  cka_reg, cka_next;

    logic [7:0]  seed_a2, seed_b2;
    logic [7:0]  add_a, add_b;
    logic [15:0] dlen_full;
    logic [16:0] pos_inc;
    logic [2:0]  check_status;

    // Sums after class and id, then one more byte folded in.
    assign seed_a2   = cfg.message_class + cfg.message_id;
    assign seed_b2   = cfg.message_class + seed_a2;
    assign add_a     = sum_a_reg + data_byte;
    assign add_b     = sum_b_reg + add_a;
    assign dlen_full = {data_byte, dlen_reg[7:0]};
    assign pos_inc   = {1'b0, pos_reg} + 17'd1;

    always_comb begin
        if (month_reg < 8'd1 || month_reg > 8'd12) begin
            check_status = ST_MONTH;
        end else if (day_reg < 8'd1 || day_reg > 8'd31) begin
            check_status = ST_DAY;
        end else if (hour_reg > 8'd23) begin
            check_status = ST_HOUR;
        end else if (minute_reg > 8'd59) begin
            check_status = ST_MINUTE;
        end else if (second_reg > 8'd59) begin
            check_status = ST_SECOND;
        end else if (cka_reg != sum_a_reg || data_byte != sum_b_reg) begin
            check_status = ST_CHECKSUM;
        end else begin
            check_status = ST_OK;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        dlen_next   = dlen_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        cka_next    = cka_reg;
        emit        = 1'b0;
        emit_data.status = ST_OK;
        // Captures do not change in the phases that emit, so the stored values go out.
        emit_data.year   = year_reg;
        emit_data.month  = month_reg;
        emit_data.day    = day_reg;
        emit_data.hour   = hour_reg;
        emit_data.minute = minute_reg;
        emit_data.second = second_reg;

        if (in_fire) begin
            if (frame_start) begin
                // A start mark always opens a new frame and drops any frame in progress.
                sum_a_next  = seed_a2 + data_byte;
                sum_b_next  = seed_b2 + sum_a_next;
                dlen_next   = {8'd0, data_byte};
                pos_next    = '0;
                year_next   = '0;
                month_next  = '0;
                day_next    = '0;
                hour_next   = '0;
                minute_next = '0;
                second_next = '0;
                cka_next    = '0;
                phase_next  = PH_LEN_HI;
            end else begin
                unique case (phase_reg)
                    PH_LEN_HI: begin
                        dlen_next  = dlen_full;
                        sum_a_next = add_a;
                        sum_b_next = add_b;
                        pos_next   = '0;
                        if (dlen_full != cfg.expected_length) begin
                            phase_next       = PH_IDLE;
                            emit             = 1'b1;
                            emit_data.status = ST_LENGTH;
                        end else if (dlen_full == 16'd0) begin
                            phase_next = PH_CK_A;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        sum_a_next = add_a;
                        sum_b_next = add_b;
                        case (pos_reg)
                            POS_YEAR_LO: year_next[7:0]  = data_byte;
                            POS_YEAR_HI: year_next[15:8] = data_byte;
                            POS_MONTH:   month_next      = data_byte;
                            POS_DAY:     day_next        = data_byte;
                            POS_HOUR:    hour_next       = data_byte;
                            POS_MINUTE:  minute_next     = data_byte;
                            POS_SECOND:  second_next     = data_byte;
                            default: ;
                        endcase
                        if (pos_inc >= {1'b0, dlen_reg}) begin
                            phase_next = PH_CK_A;
                        end
                        pos_next = pos_inc[15:0];
                    end
                    PH_CK_A: begin
                        cka_next   = data_byte;
                        phase_next = PH_CK_B;
                    end
                    PH_CK_B: begin
                        phase_next       = PH_IDLE;
                        emit             = 1'b1;
                        emit_data.status = check_status;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        dlen_reg   <= dlen_next;
        sum_a_reg  <= sum_a_next;
        sum_b_reg  <= sum_b_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        cka_reg    <= cka_next;
    end

endmodule

### design/ubxtmc_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on ubxtmc_pkg for result_t.
`timescale 1ns / 1ps

module ubxtmc_out_buf import ubxtmc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    can_accept,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop        = main_valid_reg & out_ready;
    // With the skid entry free there is always room for the word of one more byte.
    assign can_accept = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (main_valid_reg && !pop) begin
            if (push) begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (skid_valid_reg) begin
            main_next       = skid_reg;
            main_valid_next = 1'b1;
            skid_valid_next = 1'b0;
        end else begin
            main_next       = push_data;
            main_valid_next = push;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

### design/ubx_time_message_checker_top.sv
// UBX time message checker: one frame byte per word, at most one result word per frame.
// One byte per cycle while s_tready is high; the tracker updates all its state per byte.
// The result of the byte that closes a frame is registered in the output buffer.
// A two-entry output buffer keeps s_tready high while one result waits on m_tready.
// Reset (aresetn low, synchronous) idles the tracker, empties the buffer, restores registers.
`timescale 1ns / 1ps

module ubx_time_message_checker_top import ubxtmc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // [0] frame_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] year, [23:16] month, [31:24] day, [39:32] hour, [47:40] minute, [55:48] second
    output logic [55:0]           m_tdata,
    output logic [2:0]            m_tuser,   // [2:0] status
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t    cfg;
    result_t emit_data;
    result_t out_data;
    logic    emit;
    logic    in_fire;

    assign in_fire = s_tvalid & s_tready;

    ubxtmc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ubxtmc_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .data_byte   (s_tdata),
        .frame_start (s_tuser),
        .cfg         (cfg),
        .emit        (emit),
        .emit_data   (emit_data)
    );

    ubxtmc_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (emit),
        .push_data  (emit_data),
        .can_accept (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    assign m_tuser = out_data.status;
    assign m_tdata = {out_data.second, out_data.minute, out_data.hour,
                      out_data.day, out_data.month, out_data.year};

endmodule

### bench/tb_ubx_time_message_checker_top.sv
// Self-checking testbench for ubx_time_message_checker_top: frame bytes in, one status word out.
// Directed frames from a table, then random frames under several register settings.
// Depends on ubxtmc_pkg and the checker RTL only.
`timescale 1ns / 1ps

module tb_ubx_time_message_checker_top import ubxtmc_pkg::*; ();

    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic [1:0] CK_GOOD  = 2'd0;
    localparam logic [1:0] CK_BAD_A = 2'd1;
    localparam logic [1:0] CK_BAD_B = 2'd2;

    localparam logic [2:0] TRK_IDLE    = 3'd0;
    localparam logic [2:0] TRK_LEN_HI  = 3'd1;
    localparam logic [2:0] TRK_PAYLOAD = 3'd2;
    localparam logic [2:0] TRK_CK_A    = 3'd3;
    localparam logic [2:0] TRK_CK_B    = 3'd4;

    // One directed frame. cut_at limits the bytes sent (0 sends the whole frame).
    typedef struct packed {
        logic [15:0] reg_len;
        logic [15:0] decl_len;
        logic [15:0] yr;
        logic [7:0]  mo;
        logic [7:0]  dy;
        logic [7:0]  hr;
        logic [7:0]  mi;
        logic [7:0]  se;
        logic [1:0]  ck_fault;
        logic [7:0]  cut_at;
        logic        typed;
        logic [2:0]  typed_status;
    } frame_case_t;

    localparam int N_CASES = 22;

    frame_case_t frame_cases [N_CASES] = '{
        '{16'd56, 16'd56, 16'd2024, 8'd6, 8'd15, 8'd12, 8'd30, 8'd45, CK_GOOD, 8'd0, 1'b1, ST_OK},
        '{16'd15, 16'd15, 16'hFFFF, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59, CK_GOOD, 8'd0, 1'b1, ST_OK},
        '{16'd15, 16'd15, 16'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, CK_GOOD, 8'd0, 1'b1, ST_OK},
        '{16'd15, 16'd15, 16'd2000, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, CK_GOOD, 8'd0, 1'b1, ST_MONTH},
        '{16'd15, 16'd15, 16'd2001, 8'd13, 8'd1, 8'd0, 8'd0, 8'd0, CK_GOOD, 8'd0, 1'b1, ST_MONTH},
        '{16'd15, 16'd15, 16'd2002, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, CK_GOOD, 8'd0, 1'b1, ST_DAY},
        '{16'd15, 16'd15, 16'd2003, 8'd1, 8'd32, 8'd0, 8'd0, 8'd0, CK_GOOD, 8'd0, 1'b1, ST_DAY},
        '{16'd15, 16'd15, 16'd2004, 8'd1, 8'd1, 8'd24, 8'd0, 8'd0, CK_GOOD, 8'd0, 1'b1, ST_HOUR},
        '{16'd15, 16'd15, 16'd2005, 8'd1, 8'd1, 8'd0, 8'd60, 8'd0, CK_GOOD, 8'd0, 1'b1, ST_MINUTE},
        '{16'd15, 16'd15, 16'd2006, 8'd1, 8'd1, 8'd0, 8'd0, 8'd60, CK_GOOD, 8'd0, 1'b1, ST_SECOND},
        '{16'd15, 16'd15, 16'h8000, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, CK_GOOD, 8'd0,
          1'b1, ST_MONTH},
        '{16'd15, 16'd15, 16'h00FF, 8'd12, 8'd31, 8'd255, 8'd255, 8'd255, CK_GOOD, 8'd0,
          1'b1, ST_HOUR},
        '{16'd15, 16'd15, 16'hFF00, 8'd12, 8'd31, 8'd23, 8'd255, 8'd255, CK_GOOD, 8'd0,
          1'b1, ST_MINUTE},
        '{16'd15, 16'd15, 16'd2010, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, CK_BAD_A, 8'd0, 1'b1, ST_CHECKSUM},
        '{16'd15, 16'd15, 16'd2011, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, CK_BAD_B, 8'd0, 1'b1, ST_CHECKSUM},
        '{16'd15, 16'd15, 16'd2012, 8'd0, 8'd4, 8'd5, 8'd6, 8'd7, CK_BAD_A, 8'd0, 1'b1, ST_MONTH},
        '{16'd15, 16'd14, 16'd2013, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, CK_GOOD, 8'd0, 1'b1, ST_LENGTH},
        '{16'd15, 16'hFFFF, 16'd2014, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, CK_GOOD, 8'd0, 1'b1, ST_LENGTH},
        '{16'd15, 16'h010F, 16'd2015, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, CK_GOOD, 8'd0, 1'b1, ST_LENGTH},
        '{16'd15, 16'd15, 16'd2016, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, CK_GOOD, 8'd9, 1'b0, ST_OK},
        '{16'd15, 16'd15, 16'd2017, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, CK_GOOD, 8'd1, 1'b0, ST_OK},
        '{16'd15, 16'd15, 16'd2018, 8'd11, 8'd30, 8'd22, 8'd58, 8'd57, CK_GOOD, 8'd0, 1'b0, ST_OK}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] data_byte
    logic                  s_tuser;   // [0] frame_start
    logic                  m_tvalid;
    logic                  m_tready;
    // [15:0] year, [23:16] month, [31:24] day, [39:32] hour, [47:40] minute, [55:48] second
    logic [55:0]           m_tdata;
    logic [2:0]            m_tuser;   // [2:0] status
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Register and frame tracker state mirrored by the testbench.
    cfg_t        reg_model = '{CLASS_RESET, ID_RESET, LENGTH_RESET};
    logic [2:0]  trk_phase = TRK_IDLE;
    logic [15:0] trk_pos = '0;
    logic [15:0] trk_len = '0;
    logic [15:0] fl_sum = '0;        // {sum_b, sum_a}
    logic [15:0] cap_year = '0;
    logic [7:0]  cap_time [5] = '{default: 8'h00};
    logic [7:0]  cap_ck_a = '0;

    result_t     expected_reports [$];
    result_t     typed_report;
    bit          typed_pending = 1'b0;
    bit          src_lazy = 1'b0;
    bit          sink_lazy = 1'b1;
    int          useful_bytes = 0;
    int          error_count = 0;
    result_t     oldest_report;

    ubx_time_message_checker_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("ubx_time_message_checker_top test failed");
        $finish;
    end

    function automatic logic [15:0] fletcher_step(logic [15:0] sums, logic [7:0] x);
        logic [7:0] a;
        logic [7:0] b;
        a = sums[7:0] + x;
        b = sums[15:8] + a;
        return {b, a};
    endfunction

    function automatic result_t capture_report(logic [2:0] code);
        result_t r;
        r.status = code;
        r.year   = cap_year;
        r.month  = cap_time[0];
        r.day    = cap_time[1];
        r.hour   = cap_time[2];
        r.minute = cap_time[3];
        r.second = cap_time[4];
        return r;
    endfunction

    // Advances the mirrored tracker by one accepted byte; got is set when a report is due.
    task automatic track_frame_byte(input logic [7:0] b, input logic st,
                                    output bit got, output result_t rep);
        logic [2:0] code;
        got = 1'b0;
        rep = '0;
        if (st || trk_phase != TRK_IDLE)
            useful_bytes++;
        if (st) begin
            fl_sum = fletcher_step(fletcher_step(fletcher_step(16'h0, reg_model.message_class),
                                                 reg_model.message_id), b);
            trk_len   = {8'h00, b};
            trk_pos   = '0;
            cap_year  = '0;
            cap_time  = '{default: 8'h00};
            cap_ck_a  = '0;
            trk_phase = TRK_LEN_HI;
        end else begin
            case (trk_phase)
                TRK_LEN_HI: begin
                    trk_len[15:8] = b;
                    fl_sum = fletcher_step(fl_sum, b);
                    trk_pos = '0;
                    if (trk_len != reg_model.expected_length) begin
                        trk_phase = TRK_IDLE;
                        got = 1'b1;
                        rep = capture_report(ST_LENGTH);
                    end else begin
                        trk_phase = (trk_len == 16'd0) ? TRK_CK_A : TRK_PAYLOAD;
                    end
                end
                TRK_PAYLOAD: begin
                    fl_sum = fletcher_step(fl_sum, b);
                    if (trk_pos == POS_YEAR_LO)
                        cap_year[7:0] = b;
                    else if (trk_pos == POS_YEAR_HI)
                        cap_year[15:8] = b;
                    else if (trk_pos >= POS_MONTH && trk_pos <= POS_SECOND)
                        cap_time[trk_pos - POS_MONTH] = b;
                    if ({1'b0, trk_pos} + 17'd1 >= {1'b0, trk_len})
                        trk_phase = TRK_CK_A;
                    trk_pos = trk_pos + 16'd1;
                end
                TRK_CK_A: begin
                    cap_ck_a  = b;
                    trk_phase = TRK_CK_B;
                end
                TRK_CK_B: begin
                    trk_phase = TRK_IDLE;
                    // Range checks come first, in field order; the checksum only decides
                    // when every captured field is in range.
                    if (cap_time[0] < 8'd1 || cap_time[0] > 8'd12)
                        code = ST_MONTH;
                    else if (cap_time[1] < 8'd1 || cap_time[1] > 8'd31)
                        code = ST_DAY;
                    else if (cap_time[2] > 8'd23)
                        code = ST_HOUR;
                    else if (cap_time[3] > 8'd59)
                        code = ST_MINUTE;
                    else if (cap_time[4] > 8'd59)
                        code = ST_SECOND;
                    else if (cap_ck_a != fl_sum[7:0] || b != fl_sum[15:8])
                        code = ST_CHECKSUM;
                    else
                        code = ST_OK;
                    got = 1'b1;
                    rep = capture_report(code);
                end
                default: trk_phase = TRK_IDLE;
            endcase
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic st);
        int      gap;
        bit      got;
        result_t rep;
        if ($urandom_range(0, 63) == 0)
            src_lazy = !src_lazy;
        gap = src_lazy ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = st;
        do @(posedge aclk); while (s_tready !== 1'b1);
        track_frame_byte(b, st, got, rep);
        if (got)
            expected_reports.push_back(typed_pending ? typed_report : rep);
        @(negedge aclk);
    endtask

    // Holds the input side until every expected word has come out and the block has settled.
    task automatic hold_until_drained();
        s_tvalid = 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        case (idx)
            REG_CLASS:  reg_model.message_class   = value[7:0];
            REG_ID:     reg_model.message_id      = value[7:0];
            REG_LENGTH: reg_model.expected_length = value[15:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Sends one frame with a correct or damaged checksum; a length that the block will
    // reject stops after the two length bytes, and a nonzero cut_at can stop it earlier.
    task automatic send_frame(input logic [15:0] decl, input logic [15:0] yr,
                              input logic [7:0] mo, input logic [7:0] dy, input logic [7:0] hr,
                              input logic [7:0] mi, input logic [7:0] se,
                              input logic [1:0] ck_fault, input int cut_at);
        int          full;
        int          total;
        logic [15:0] p;
        logic [15:0] run;
        logic [7:0]  b;
        logic [7:0]  flip;
        full  = int'(decl) + 4;
        total = (decl != reg_model.expected_length) ? 2 : full;
        if (cut_at > 0 && cut_at < total)
            total = cut_at;
        run  = fletcher_step(fletcher_step(16'h0, reg_model.message_class),
                             reg_model.message_id);
        flip = 8'($urandom_range(1, 255));
        for (int k = 0; k < total; k++) begin
            if (k == 0) begin
                b = decl[7:0];
            end else if (k == 1) begin
                b = decl[15:8];
            end else if (k < full - 2) begin
                p = 16'(k - 2);
                case (p)
                    POS_YEAR_LO: b = yr[7:0];
                    POS_YEAR_HI: b = yr[15:8];
                    POS_MONTH:   b = mo;
                    POS_DAY:     b = dy;
                    POS_HOUR:    b = hr;
                    POS_MINUTE:  b = mi;
                    POS_SECOND:  b = se;
                    default:     b = 8'($urandom_range(0, 255));
                endcase
            end else if (k == full - 2) begin
                b = run[7:0] ^ ((ck_fault == CK_BAD_A) ? flip : 8'h00);
            end else begin
                b = run[15:8] ^ ((ck_fault == CK_BAD_B) ? flip : 8'h00);
            end
            if (k < full - 2)
                run = fletcher_step(run, b);
            push_byte(b, k == 0);
        end
    endtask

    function automatic logic [7:0] time_byte(int lo, int hi);
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(lo, hi));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_frame();
        int          kind;
        int          cut;
        logic [15:0] decl;
        logic [1:0]  ck_fault;
        kind     = $urandom_range(0, 99);
        decl     = reg_model.expected_length;
        cut      = 0;
        ck_fault = CK_GOOD;
        if ($urandom_range(0, 9) == 0)
            ck_fault = ($urandom_range(0, 1) == 0) ? CK_BAD_A : CK_BAD_B;
        if (kind < 65) begin
            // Long declared lengths are cut short and dropped by the next start.
            if (decl > 16'd64)
                cut = $urandom_range(2, 30);
        end else if (kind < 75) begin
            decl = decl ^ 16'($urandom_range(1, 65535));
        end else if (kind < 85) begin
            cut = $urandom_range(1, (int'(decl) + 3 < 40) ? int'(decl) + 3 : 40);
        end else if (kind < 93) begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            return;
        end else begin
            repeat ($urandom_range(1, 6))
                push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
            return;
        end
        send_frame(decl, 16'($urandom_range(0, 65535)), time_byte(1, 12), time_byte(1, 31),
                   time_byte(0, 23), time_byte(0, 59), time_byte(0, 59), ck_fault, cut);
    endtask

    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_reports.size() == 0) begin
                $error("result word with no expectation, status %0d", m_tuser);
                error_count++;
            end else begin
                oldest_report = expected_reports.pop_front();
                check_field("status", 16'(oldest_report.status), 16'(m_tuser));
                check_field("year", oldest_report.year, m_tdata[15:0]);
                check_field("month", 16'(oldest_report.month), 16'(m_tdata[23:16]));
                check_field("day", 16'(oldest_report.day), 16'(m_tdata[31:24]));
                check_field("hour", 16'(oldest_report.hour), 16'(m_tdata[39:32]));
                check_field("minute", 16'(oldest_report.minute), 16'(m_tdata[47:40]));
                check_field("second", 16'(oldest_report.second), 16'(m_tdata[55:48]));
            end
        end
    end

    // Result side: random stalls per word, with stretches of constant readiness.
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            if ($urandom_range(0, 63) == 0)
                sink_lazy = !sink_lazy;
            stall = sink_lazy ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            @(negedge aclk);
        end
    end

    initial begin
        frame_case_t row;
        logic [7:0]  cls;
        logic [7:0]  mid;
        logic [15:0] rlen;
        int          phase_start;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < N_CASES; i++) begin
            row = frame_cases[i];
            if (row.reg_len != reg_model.expected_length) begin
                hold_until_drained();
                cfg_write(REG_LENGTH, 32'(row.reg_len));
            end
            typed_report.status = row.typed_status;
            if (row.typed_status == ST_LENGTH) begin
                typed_report.year   = '0;
                typed_report.month  = '0;
                typed_report.day    = '0;
                typed_report.hour   = '0;
                typed_report.minute = '0;
                typed_report.second = '0;
            end else begin
                typed_report.year   = row.yr;
                typed_report.month  = row.mo;
                typed_report.day    = row.dy;
                typed_report.hour   = row.hr;
                typed_report.minute = row.mi;
                typed_report.second = row.se;
            end
            typed_pending = row.typed;
            send_frame(row.decl_len, row.yr, row.mo, row.dy, row.hr, row.mi, row.se,
                       row.ck_fault, int'(row.cut_at));
            typed_pending = 1'b0;
        end
        // Stray bytes outside a frame must be ignored.
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);

        src_lazy = 1'b1;
        for (int ph = 0; ph < 12; ph++) begin
            hold_until_drained();
            case (ph)
                0: begin
                    cls  = 8'h00;
                    mid  = 8'h00;
                    rlen = 16'd0;
                end
                1: begin
                    cls  = 8'hFF;
                    mid  = 8'hFF;
                    rlen = 16'hFFFF;
                end
                default: begin
                    cls  = 8'($urandom_range(0, 255));
                    mid  = 8'($urandom_range(0, 255));
                    rlen = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 14))
                                                       : 16'($urandom_range(15, 40));
                end
            endcase
            cfg_write(REG_CLASS, ($urandom & 32'hFFFF_FF00) | 32'(cls));
            cfg_write(REG_ID, ($urandom & 32'hFFFF_FF00) | 32'(mid));
            cfg_write(REG_LENGTH, ($urandom & 32'hFFFF_0000) | 32'(rlen));
            if (ph == 2)
                cfg_write(REG_UNUSED, $urandom);
            phase_start = useful_bytes;
            while (useful_bytes - phase_start < 100)
                random_frame();
        end

        s_tvalid = 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("ubx_time_message_checker_top test passed");
        else
            $display("ubx_time_message_checker_top test failed");
        $finish;
    end

endmodule
